[rtl/core/rbr_pkg.sv]
// Shared constants for the RGB brightness rescale pipeline.
package rbr_pkg;

   localparam int PCT_BITS = 7;

   localparam logic [PCT_BITS-1:0] PCT_MIN = 7'd1;
   localparam logic [PCT_BITS-1:0] PCT_MAX = 7'd100;

   localparam int NUM_CHANNELS = 3;

endpackage

[rtl/core/rbr_front.sv]
// Front end: clamp, peak search, products and dividends for the three channels.
module rbr_front
   import rbr_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [CHANNEL_BITS-1:0]                  in_red,
   input  logic [CHANNEL_BITS-1:0]                  in_green,
   input  logic [CHANNEL_BITS-1:0]                  in_blue,
   input  logic [PCT_BITS-1:0]                      in_level,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [CHANNEL_BITS+PCT_BITS-1:0]         out_den,
   output logic [2*CHANNEL_BITS+PCT_BITS-1:0]       out_num [NUM_CHANNELS]
);

   localparam int CB = CHANNEL_BITS;
   localparam int MW = CHANNEL_BITS + PCT_BITS;
   localparam int NW = 2 * CHANNEL_BITS + PCT_BITS;

   // stage 1: clamped level, channels and peak
   logic                v1_ff;
   logic [CB-1:0]       chan1_ff [NUM_CHANNELS];
   logic [CB-1:0]       chan1_in [NUM_CHANNELS];
   logic [CB-1:0]       peak1_ff, peak1_in;
   logic [PCT_BITS-1:0] pct1_ff, pct1_in;
   // stage 2: channel times level, peak times full percent
   logic                v2_ff;
   logic [MW-1:0]       prod2_ff [NUM_CHANNELS];
   logic [MW-1:0]       prod2_in [NUM_CHANNELS];
   logic [MW-1:0]       den2_ff, den2_in;
   // stage 3: product times full scale
   logic                v3_ff;
   logic [NW-1:0]       num3_ff [NUM_CHANNELS];
   logic [NW-1:0]       num3_in [NUM_CHANNELS];
   logic [MW-1:0]       den3_ff;

   logic rdy1, rdy2, rdy3;
   logic [CB-1:0] hi_w, lo_w;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      hi_w = in_red;
      lo_w = in_red;
      if (in_green > hi_w) hi_w = in_green;
      if (in_blue > hi_w) hi_w = in_blue;
      if (in_green < lo_w) lo_w = in_green;
      if (in_blue < lo_w) lo_w = in_blue;

      if (in_level < PCT_MIN) begin
         pct1_in = PCT_MIN;
      end else if (in_level > PCT_MAX) begin
         pct1_in = PCT_MAX;
      end else begin
         pct1_in = in_level;
      end

      // a gray pixel scales like a channel equal to its peak: use one over one
      if (hi_w == lo_w) begin
         chan1_in[0] = CB'(1);
         chan1_in[1] = CB'(1);
         chan1_in[2] = CB'(1);
         peak1_in    = CB'(1);
      end else begin
         chan1_in[0] = in_red;
         chan1_in[1] = in_green;
         chan1_in[2] = in_blue;
         peak1_in    = hi_w;
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         prod2_in[ch] = MW'(chan1_ff[ch]) * MW'(pct1_ff);
         num3_in[ch]  = (NW'(prod2_ff[ch]) << CB) - NW'(prod2_ff[ch]);
      end
      den2_in = MW'(peak1_ff) * MW'(PCT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         chan1_ff <= chan1_in;
         peak1_ff <= peak1_in;
         pct1_ff  <= pct1_in;
      end
      if (rdy2 && v1_ff) begin
         prod2_ff <= prod2_in;
         den2_ff  <= den2_in;
      end
      if (rdy3 && v2_ff) begin
         num3_ff <= num3_in;
         den3_ff <= den2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_den   = den3_ff;
   assign out_num   = num3_ff;

endmodule

[rtl/core/rbr_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for three dividends.
module rbr_divider
   import rbr_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [CHANNEL_BITS+PCT_BITS-1:0]         in_den,
   input  logic [2*CHANNEL_BITS+PCT_BITS-1:0]       in_num [NUM_CHANNELS],
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [CHANNEL_BITS-1:0]                  out_quo [NUM_CHANNELS]
);

   localparam int CB = CHANNEL_BITS;
   localparam int MW = CHANNEL_BITS + PCT_BITS;
   localparam int NW = 2 * CHANNEL_BITS + PCT_BITS;

   logic          valid_ff  [CB];
   logic          stg_ready [CB];
   logic [CB-1:0] quo_ff    [CB][NUM_CHANNELS];
   // the last stage keeps only the quotient
   logic [MW-1:0] den_ff    [CB-1];
   logic [NW-1:0] rem_ff    [CB-1][NUM_CHANNELS];

   for (genvar s = 0; s < CB; s++) begin : g_stage
      localparam int SHIFT = CB - 1 - s;

      logic          prev_valid;
      logic          next_ready;
      logic [MW-1:0] den_w;
      logic [NW-1:0] rem_w  [NUM_CHANNELS];
      logic [CB-1:0] quo_w  [NUM_CHANNELS];
      logic [NW:0]   diff_w [NUM_CHANNELS];
      logic          bit_w  [NUM_CHANNELS];
      logic [CB-1:0] quo_in [NUM_CHANNELS];

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign den_w      = in_den;
         assign rem_w      = in_num;
         assign quo_w[0]   = '0;
         assign quo_w[1]   = '0;
         assign quo_w[2]   = '0;
      end else begin : g_mid
         assign prev_valid = valid_ff[s-1];
         assign den_w      = den_ff[s-1];
         assign rem_w      = rem_ff[s-1];
         assign quo_w      = quo_ff[s-1];
      end

      if (s == CB - 1) begin : g_tail
         assign next_ready = out_ready;
      end else begin : g_link
         assign next_ready = stg_ready[s+1];
      end

      assign stg_ready[s] = !valid_ff[s] || next_ready;

      always_comb begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            diff_w[ch] = {1'b0, rem_w[ch]} - {1'b0, NW'(den_w) << SHIFT};
            bit_w[ch]  = !diff_w[ch][NW];
            quo_in[ch] = {quo_w[ch][CB-2:0], bit_w[ch]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stg_ready[s]) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_ready[s] && prev_valid) begin
            quo_ff[s] <= quo_in;
         end
      end

      if (s < CB - 1) begin : g_keep
         logic [NW-1:0] rem_in [NUM_CHANNELS];

         always_comb begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
               // restore: keep the old remainder when the trial goes negative
               rem_in[ch] = bit_w[ch] ? diff_w[ch][NW-1:0] : rem_w[ch];
            end
         end

         always_ff @(posedge clock) begin
            if (stg_ready[s] && prev_valid) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_w;
            end
         end
      end
   end

   assign in_ready  = stg_ready[0];
   assign out_valid = valid_ff[CB-1];
   assign out_quo   = quo_ff[CB-1];

endmodule

[rtl/core/rgb_brightness_rescale.sv]
// Top level: HSV value brightness rescale of one RGB pixel per clock unless stalled.
//
//  channel | ports                                           | transfer when
//  --------+-------------------------------------------------+----------------------
//  request | req_red_in req_green_in req_blue_in             | req_valid && !req_stall
//          | req_level_percent                               |
//  response| rsp_red_out rsp_green_out rsp_blue_out          | rsp_valid && !rsp_stall
//
// One pixel enters per clock while req_stall is low and passes through three
// front stages (clamp and peak, products, dividends) and one divider stage per
// quotient bit. Each stage holds only while its successor is full and stalled,
// so empty stages fill up under rsp_stall. Synchronous reset clears the valid
// bits only; there is no state between pixels.
module rgb_brightness_rescale
   import rbr_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHANNEL_BITS-1:0] req_red_in,
   input  logic [CHANNEL_BITS-1:0] req_green_in,
   input  logic [CHANNEL_BITS-1:0] req_blue_in,
   input  logic [PCT_BITS-1:0]     req_level_percent,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0] rsp_red_out,
   output logic [CHANNEL_BITS-1:0] rsp_green_out,
   output logic [CHANNEL_BITS-1:0] rsp_blue_out
);

   localparam int MW = CHANNEL_BITS + PCT_BITS;
   localparam int NW = 2 * CHANNEL_BITS + PCT_BITS;

   logic                    req_ready;
   logic                    mid_valid;
   logic                    mid_ready;
   logic [MW-1:0]           mid_den;
   logic [NW-1:0]           mid_num [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] quo     [NUM_CHANNELS];

   rbr_front #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red_in),
      .in_green  (req_green_in),
      .in_blue   (req_blue_in),
      .in_level  (req_level_percent),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_den   (mid_den),
      .out_num   (mid_num)
   );

   rbr_divider #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_den    (mid_den),
      .in_num    (mid_num),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_quo   (quo)
   );

   assign req_stall     = !req_ready;
   assign rsp_red_out   = quo[0];
   assign rsp_green_out = quo[1];
   assign rsp_blue_out  = quo[2];

endmodule
